// File: rtl/pba_pkg.sv
// Shared types, constants and state codes of the page bitmap allocator.
`default_nettype none

package pba_pkg;

  // Map geometry
  localparam int NUM_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 24;
  localparam int COUNT_W    = 13;
  localparam int MAP_BITS   = 32;
  localparam int BIT_W      = $clog2(MAP_BITS);
  localparam int MAP_WORDS  = (NUM_PAGES + MAP_BITS - 1) / MAP_BITS;
  localparam int WORD_W     = $clog2(MAP_WORDS);
  localparam int PG_W       = ADDR_W - PAGE_SHIFT;

  // Full-word summary is searched in groups
  localparam int GRP_SIZE   = 8;
  localparam int GRP_W      = $clog2(GRP_SIZE);
  localparam int NUM_GRPS   = MAP_WORDS / GRP_SIZE;
  localparam int NGRP_W     = $clog2(NUM_GRPS);

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_MARK    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_REINIT  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] page_addr;
  } pba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  result_addr;
    logic               status;
    logic [COUNT_W-1:0] used_count;
  } pba_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_MODIFY,
    ST_RESPOND
  } pba_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic read;
    logic modify;
    logic respond;
  } pba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e new_kind;
    logic  new_in_range;
    logic  no_free;
    logic  out_free;
  } pba_status_t;

endpackage

`default_nettype wire

// File: rtl/pba_ctrl.sv
// Sequencing state machine of the page bitmap allocator.
`default_nettype none

module pba_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire pba_pkg::pba_status_t status_i,
  output pba_pkg::pba_cmd_t         cmd_o
);
  import pba_pkg::*;

  pba_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (status_i.new_kind)
            KIND_ALLOC:  state_d = ST_SCAN;
            KIND_REINIT: state_d = ST_MODIFY;
            default: begin
              state_d = status_i.new_in_range ? ST_READ : ST_RESPOND;
            end
          endcase
        end
      end
      ST_SCAN:    state_d = status_i.no_free ? ST_RESPOND : ST_READ;
      ST_READ:    state_d = ST_MODIFY;
      ST_MODIFY:  state_d = ST_RESPOND;
      ST_RESPOND: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.accept  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan    = (state_q == ST_SCAN);
    cmd_o.read    = (state_q == ST_READ);
    cmd_o.modify  = (state_q == ST_MODIFY);
    cmd_o.respond = (state_q == ST_RESPOND) && status_i.out_free;
    in_stall_o    = (state_q != ST_IDLE);
  end

endmodule

`default_nettype wire

// File: rtl/pba_dpath.sv
// Bitmap memory, full-word summary, search encoders, counter and output word.
`default_nettype none

module pba_dpath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pba_pkg::pba_in_t     in_data_i,
  input  wire pba_pkg::pba_cmd_t    cmd_i,
  output pba_pkg::pba_status_t      status_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pba_pkg::pba_out_t         out_data_o
);
  import pba_pkg::*;

  // Lowest clear bit of a map word
  function automatic logic [BIT_W-1:0] first_zero_bit(logic [MAP_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = MAP_BITS - 1; i >= 0; i--) begin
      if (!v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Lowest clear flag within a group of full flags
  function automatic logic [GRP_W-1:0] first_zero_grp(logic [GRP_SIZE-1:0] v);
    logic [GRP_W-1:0] idx;
    idx = '0;
    for (int i = GRP_SIZE - 1; i >= 0; i--) begin
      if (!v[i]) idx = GRP_W'(i);
    end
    return idx;
  endfunction

  // Lowest set flag among groups
  function automatic logic [NGRP_W-1:0] first_set_grp(logic [NUM_GRPS-1:0] v);
    logic [NGRP_W-1:0] idx;
    idx = '0;
    for (int i = NUM_GRPS - 1; i >= 0; i--) begin
      if (v[i]) idx = NGRP_W'(i);
    end
    return idx;
  endfunction

  logic [MAP_BITS-1:0] map_mem [MAP_WORDS];

  logic [MAP_WORDS-1:0] valid_q, valid_d;
  logic [MAP_WORDS-1:0] full_q, full_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  kind_e                kind_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [ADDR_W-1:0]    res_q, res_d;
  logic                 fail_q, fail_d;
  logic [NGRP_W-1:0]    grp_q;
  logic [WORD_W-1:0]    word_q;
  logic [MAP_BITS-1:0]  rd_data_q;
  logic                 rd_valid_q;
  logic                 out_valid_q;
  pba_out_t             out_q;

  logic [NUM_GRPS-1:0]  grp_free;
  logic [PG_W-1:0]      pg_in, pg;
  logic [WORD_W-1:0]    rd_addr;
  logic [MAP_BITS-1:0]  cur_word, new_word;
  logic [BIT_W-1:0]     bit_idx;
  logic [PG_W-1:0]      found_pg;
  logic                 found_ok;
  logic                 bit_was_set;
  logic                 mem_we;

  // Group summary of words that still have a free page
  always_comb begin
    for (int g = 0; g < NUM_GRPS; g++) begin
      grp_free[g] = ~&full_q[g*GRP_SIZE +: GRP_SIZE];
    end
  end

  assign pg_in = in_data_i.page_addr[ADDR_W-1:PAGE_SHIFT];
  assign pg    = addr_q[ADDR_W-1:PAGE_SHIFT];

  // Status to the controller
  always_comb begin
    status_o.new_kind     = in_data_i.kind;
    status_o.new_in_range = (32'(pg_in) < NUM_PAGES);
    status_o.no_free      = ~|grp_free;
    status_o.out_free     = !out_valid_q || !out_stall_i;
  end

  // Read address: first non-full word for allocate, else the page's word
  always_comb begin
    if (kind_q == KIND_ALLOC) begin
      rd_addr = {grp_q, first_zero_grp(full_q[grp_q*GRP_SIZE +: GRP_SIZE])};
    end else begin
      rd_addr = pg[PG_W-1:BIT_W];
    end
  end

  // Word as read, unwritten words take their reset contents
  always_comb begin
    if (rd_valid_q) begin
      cur_word = rd_data_q;
    end else if (word_q == '0) begin
      cur_word = MAP_BITS'(1);
    end else begin
      cur_word = '0;
    end
  end

  // Modify the read word
  always_comb begin
    bit_idx     = (kind_q == KIND_ALLOC) ? first_zero_bit(cur_word) : pg[BIT_W-1:0];
    found_pg    = {word_q, bit_idx};
    found_ok    = (32'(found_pg) < NUM_PAGES);
    bit_was_set = cur_word[bit_idx];
    new_word    = cur_word;
    if (kind_q == KIND_RELEASE) begin
      new_word[bit_idx] = 1'b0;
    end else begin
      new_word[bit_idx] = 1'b1;
    end
  end

  // Next values of map summary, count and result
  always_comb begin
    valid_d = valid_q;
    full_d  = full_q;
    count_d = count_q;
    res_d   = res_q;
    fail_d  = fail_q;
    mem_we  = 1'b0;
    if (cmd_i.accept) begin
      res_d  = in_data_i.page_addr;
      fail_d = 1'b0;
    end
    if (cmd_i.scan && status_o.no_free) begin
      res_d  = '0;
      fail_d = 1'b1;
    end
    if (cmd_i.modify) begin
      unique case (kind_q)
        KIND_REINIT: begin
          valid_d = '0;
          full_d  = '0;
          count_d = COUNT_W'(1);
        end
        KIND_ALLOC: begin
          if (found_ok) begin
            mem_we          = 1'b1;
            valid_d[word_q] = 1'b1;
            full_d[word_q]  = &new_word;
            count_d         = count_q + COUNT_W'(1);
            res_d           = ADDR_W'(found_pg) << PAGE_SHIFT;
          end else begin
            res_d  = '0;
            fail_d = 1'b1;
          end
        end
        KIND_MARK: begin
          mem_we          = 1'b1;
          valid_d[word_q] = 1'b1;
          full_d[word_q]  = &new_word;
          if (!bit_was_set) count_d = count_q + COUNT_W'(1);
        end
        KIND_RELEASE: begin
          mem_we          = 1'b1;
          valid_d[word_q] = 1'b1;
          full_d[word_q]  = &new_word;
          if (bit_was_set) count_d = count_q - COUNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      full_q      <= '0;
      count_q     <= COUNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      full_q  <= full_d;
      count_q <= count_d;
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    fail_q <= fail_d;
    if (cmd_i.accept) begin
      kind_q <= in_data_i.kind;
      addr_q <= in_data_i.page_addr;
    end
    if (cmd_i.scan) begin
      grp_q <= first_set_grp(grp_free);
    end
    if (cmd_i.read) begin
      word_q     <= rd_addr;
      rd_valid_q <= valid_q[rd_addr];
    end
    if (cmd_i.respond) begin
      out_q.result_addr <= res_q;
      out_q.status      <= fail_q;
      out_q.used_count  <= count_q;
    end
  end

  // Bitmap memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_data_q <= map_mem[rd_addr];
    end
    if (mem_we) begin
      map_mem[word_q] <= new_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A full flag only stands for a word that has been written
  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q & ~valid_q) == '0)
    else $error("full flag set on an unwritten word");

  // The count never exceeds the number of pages
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= NUM_PAGES)
    else $error("used page count out of range");

  // Reinitialize leaves exactly one page in use
  a_reinit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.modify && (kind_q == KIND_REINIT) |=> count_q == COUNT_W'(1))
    else $error("reinitialize did not restore the count");

  // A result word is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !cmd_i.respond)
    else $error("result word overwritten while stalled");

endmodule

`default_nettype wire

// File: rtl/page_bitmap_allocator_top.sv
// Top level of the page bitmap allocator: controller and datapath.
//
// Usage: one request word enters on the input channel (kind, page_addr)
// and exactly one result word (result_addr, status, used_count) leaves
// on the output channel, in request order. A word moves at a rising
// edge where valid is high and stall is low.
// Allocate returns the lowest free page; mark and release set or clear
// the bit of the page given; reinitialize clears the map to page 0 used.
// From the accepting edge, an allocate goes through the group scan of
// the full-word flags, the memory read, the read-modify-write and the
// output load, or from the scan to the output load when no page is
// free; mark/release go through read, read-modify-write and output
// load, reinitialize through the modify and output load, and an
// out-of-range mark/release through the output load alone.
// Requests are processed one at a time; the next one is accepted the
// cycle after its result is loaded.
// Reset, asynchronous and active low, clears the per-word valid and
// full flags at once, so the map reads as page 0 used with no sweep.
// While the receiver stalls, the result word holds; a request taken
// meanwhile waits until its own result can be loaded.
`default_nettype none

module page_bitmap_allocator_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pba_pkg::pba_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pba_pkg::pba_out_t      out_data_o
);
  import pba_pkg::*;

  pba_cmd_t    cmd;
  pba_status_t status;

  pba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pba_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: test/pba_checker.sv
// Checker for the page bitmap allocator: predicts every result word and compares it.
`timescale 1ns / 100ps

module pba_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire pba_pkg::pba_in_t  in_data_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire pba_pkg::pba_out_t out_data_i,
  output int                     err_count_o,
  output int                     pending_o,
  output int                     checked_o,
  output int                     no_free_o
);
  import pba_pkg::*;

  localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;

  // Own copy of the frame map and its population
  logic [MAP_BITS-1:0] frame_map [MAP_WORDS];
  int unsigned         frames_used;
  pba_out_t            result_q [$];
  pba_out_t            want;

  // Clear the map to page 0 used
  function automatic void clear_frames();
    for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = '0;
    frame_map[0][0] = 1'b1;
    frames_used     = 1;
  endfunction

  // Apply one request to the map and return the word it should produce
  function automatic pba_out_t predict_result(pba_in_t req);
    pba_out_t    rsp;
    int unsigned page;
    int unsigned probe;
    bit          hit;
    rsp.result_addr = req.page_addr;
    rsp.status      = 1'b0;
    page            = req.page_addr >> PAGE_SHIFT;
    case (req.kind)
      KIND_ALLOC: begin
        // first fit: lowest clear bit wins
        hit   = 1'b0;
        probe = 0;
        while (!hit && probe < NUM_PAGES) begin
          if (!frame_map[probe / MAP_BITS][probe % MAP_BITS]) hit = 1'b1;
          else probe++;
        end
        if (hit) begin
          frame_map[probe / MAP_BITS][probe % MAP_BITS] = 1'b1;
          frames_used++;
          rsp.result_addr = ADDR_W'(probe << PAGE_SHIFT);
        end else begin
          rsp.result_addr = '0;
          rsp.status      = 1'b1;
        end
      end
      KIND_MARK: begin
        if (page < NUM_PAGES) begin
          if (!frame_map[page / MAP_BITS][page % MAP_BITS]) begin
            frame_map[page / MAP_BITS][page % MAP_BITS] = 1'b1;
            frames_used++;
          end
        end
      end
      KIND_RELEASE: begin
        if (page < NUM_PAGES) begin
          if (frame_map[page / MAP_BITS][page % MAP_BITS]) begin
            frame_map[page / MAP_BITS][page % MAP_BITS] = 1'b0;
            frames_used--;
          end
        end
      end
      default: clear_frames();
    endcase
    rsp.used_count = (frames_used > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(frames_used);
    return rsp;
  endfunction

  // Count a mismatch; show only the first few
  task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    err_count_o++;
    if (err_count_o <= 10) begin
      $display("%0t: result word %0d, %s: expected %0h, actual %0h",
               $time, checked_o, what, exp_val, act_val);
    end
  endtask

  // Queue predictions on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frames();
      result_q.delete();
      err_count_o = 0;
      pending_o   = 0;
      checked_o   = 0;
      no_free_o   = 0;
    end else begin
      if (in_valid_i && !in_stall_i) result_q.push_back(predict_result(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          note_mismatch("word with nothing outstanding, result_addr", '0,
                        out_data_i.result_addr);
        end else begin
          want = result_q.pop_front();
          if (out_data_i.result_addr !== want.result_addr)
            note_mismatch("result_addr", want.result_addr, out_data_i.result_addr);
          if (out_data_i.status !== want.status)
            note_mismatch("status", want.status, out_data_i.status);
          if (out_data_i.used_count !== want.used_count)
            note_mismatch("used_count", want.used_count, out_data_i.used_count);
          if (want.status) no_free_o++;
        end
        checked_o++;
      end
      pending_o = result_q.size();
    end
  end

endmodule

// File: test/tb_page_bitmap_allocator_top.sv
// Testbench top: drives request words into the page bitmap allocator and gives the verdict.
`timescale 1ns / 100ps

module tb_page_bitmap_allocator_top;
  import pba_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 1080;
  localparam int PHASES       = 10;
  localparam int DRAIN_CYCLES = 10;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  pba_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pba_out_t out_data_o;

  int err_count;
  int pending;
  int checked;
  int no_free;
  int cycle_count     = 0;
  int sent_by_kind[4] = '{0, 0, 0, 0};
  bit no_idle         = 1'b0;

  page_bitmap_allocator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  pba_checker result_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .no_free_o   (no_free)
  );

  // 8 ns clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("tb_page_bitmap_allocator_top: errors");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Page address: half the time in the low pages where the allocator works
  function automatic logic [ADDR_W-1:0] frame_addr();
    logic [ADDR_W-1:0] addr;
    addr = ADDR_W'($urandom);
    if ($urandom_range(0, 1) == 0) addr[ADDR_W-1:PAGE_SHIFT] = PG_W'($urandom_range(0, 95));
    return addr;
  endfunction

  // Request mix: allocate and release dominate, reinitialize is rare
  function automatic kind_e random_kind();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return KIND_ALLOC;
    if (pick < 65) return KIND_MARK;
    if (pick < 97) return KIND_RELEASE;
    return KIND_REINIT;
  endfunction

  // Offer one request word and hold it until it is taken
  task automatic send_word(input kind_e kind, input logic [ADDR_W-1:0] addr);
    int      gap;
    pba_in_t word;
    gap = no_idle ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      in_data_i  <= pba_in_t'($bits(pba_in_t)'($urandom));
      repeat (gap) @(negedge clk_i);
    end
    word.kind      = kind;
    word.page_addr = addr;
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    sent_by_kind[kind]++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and hold off until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Result side: random stall stretches
  initial begin
    int run;
    int hold;
    forever begin
      run = $urandom_range(1, 8);
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat (run - 1) @(negedge clk_i);
      hold = no_idle ? 0 : idle_len();
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
    end
  end

  // Request side
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: first fit order, word boundaries, repeats, page 0, extremes
    send_word(KIND_ALLOC,   24'h000000);
    send_word(KIND_ALLOC,   24'hFFFFFF);
    send_word(KIND_MARK,    24'hFFFFFF);
    send_word(KIND_MARK,    24'hFFF000);
    send_word(KIND_RELEASE, 24'h003ABC);
    send_word(KIND_RELEASE, 24'h000FFF);
    send_word(KIND_ALLOC,   24'h000000);
    send_word(KIND_MARK,    24'h01F000);
    send_word(KIND_MARK,    24'h020000);
    send_word(KIND_ALLOC,   24'h555555);
    send_word(KIND_RELEASE, 24'hFFFFFF);
    send_word(KIND_RELEASE, 24'h001000);
    send_word(KIND_ALLOC,   24'hAAAAAA);
    send_word(KIND_REINIT,  24'hFFFFFF);
    send_word(KIND_ALLOC,   24'h000000);
    send_word(KIND_REINIT,  24'h000000);
    send_word(KIND_RELEASE, 24'h000000);
    send_word(KIND_RELEASE, 24'h000000);
    send_word(KIND_ALLOC,   24'h123456);
    send_word(KIND_MARK,    24'hABCDEF);
    send_word(KIND_RELEASE, 24'h555555);
    send_word(KIND_MARK,    24'hAAAAAA);
    wait_drained();

    // random phases, some without idling, some ending in a full drain
    for (int phase = 0; phase < PHASES; phase++) begin
      no_idle = (phase % 4 == 3);
      for (int n = 0; n < RANDOM_WORDS / PHASES; n++) send_word(random_kind(), frame_addr());
      if (phase % 3 == 0) wait_drained();
    end

    // refill the low words back to back, then free a few pages and take them back
    no_idle = 1'b1;
    send_word(KIND_REINIT, frame_addr());
    repeat (40) send_word(KIND_ALLOC, ADDR_W'($urandom));
    no_idle = 1'b0;
    send_word(KIND_MARK,    frame_addr());
    send_word(KIND_RELEASE, 24'hFFF000);
    send_word(KIND_RELEASE, 24'h000123);
    send_word(KIND_RELEASE, frame_addr());
    repeat (4) send_word(KIND_ALLOC, ADDR_W'($urandom));
    send_word(KIND_REINIT, frame_addr());
    repeat (5) send_word(random_kind(), frame_addr());

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("sent %0d allocate, %0d mark, %0d release, %0d reinitialize words",
             sent_by_kind[KIND_ALLOC], sent_by_kind[KIND_MARK],
             sent_by_kind[KIND_RELEASE], sent_by_kind[KIND_REINIT]);
    $display("%0d results checked, %0d allocates found no free page; %0d mismatches",
             checked, no_free, err_count);
    if (err_count == 0) begin
      $display("tb_page_bitmap_allocator_top: clean");
    end else begin
      $display("tb_page_bitmap_allocator_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pba_pkg.sv
rtl/pba_ctrl.sv
rtl/pba_dpath.sv
rtl/page_bitmap_allocator_top.sv
test/pba_checker.sv
test/tb_page_bitmap_allocator_top.sv
